[hw/rtl/rrip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rrip_pkg;

    localparam int SETS         = 2048;
    localparam int WAYS         = 16;
    localparam int PC_ENTRIES   = 1024;
    localparam int ADDR_ENTRIES = 1024;

    localparam int SET_W     = $clog2(SETS);
    localparam int WAY_W     = $clog2(WAYS);
    localparam int PC_IDX_W  = $clog2(PC_ENTRIES);
    localparam int ADDR_IDX_W = $clog2(ADDR_ENTRIES);
    localparam int ADDR_W    = 48;
    localparam int LINE_W    = 32;
    localparam int LINE_LSB  = 6;
    localparam int ADDR_HASH_SHIFT = 13;
    localparam int PC_SHIFT_LO = 2;
    localparam int PC_SHIFT_HI = 11;

    // The clearing pass covers the deepest of the stores.
    localparam int CLEAR_N0 = (SETS > PC_ENTRIES) ? SETS : PC_ENTRIES;
    localparam int CLEAR_N  = (CLEAR_N0 > ADDR_ENTRIES) ? CLEAR_N0 : ADDR_ENTRIES;
    localparam int CLR_W    = $clog2(CLEAR_N);

    localparam logic [1:0] RRIP_NEAR    = 2'd0;
    localparam logic [1:0] RRIP_DISTANT = 2'd3;
    localparam logic [1:0] CTR_MAX      = 2'd3;
    localparam logic [1:0] CTR_MIN      = 2'd0;
    localparam logic [1:0] THRESH_RESET = 2'd2;

    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic REG_STREAM_THRESHOLD = 1'b0;
    localparam logic REG_REUSE_THRESHOLD  = 1'b1;

    typedef struct packed {
        logic [2*WAYS-1:0] rrip;
        logic [LINE_W-1:0] last_line;
        logic [LINE_W-1:0] prev_stride;
        logic              valid;
        logic [1:0]        score;
    } set_row_t;

endpackage

`default_nettype wire

[hw/rtl/rrip_ship_stream_replacement.sv]
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_ready  cmd, set_index, way, physical_address, pc, hit
// result    out        out_valid / out_ready victim_way (victim transactions only)
// config    in         cfg_we               cfg_index, cfg_data
//
// A victim transaction goes from acceptance through the registered set-row read, then
// one or two passes of the scan and aging unit, to the result.
// An update transaction runs through row and counter read, stream and counter
// training, then the row write-back.
// After reset a clearing pass over 2048 entries initializes all stores; in_ready is low.
// A result that is not taken holds the scan unit until out_ready frees the output register.
`timescale 1ns / 1ps
`default_nettype none

module rrip_ship_stream_replacement
    import rrip_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  cmd,
    input  wire logic [SET_W-1:0]      set_index,
    input  wire logic [WAY_W-1:0]      way,
    input  wire logic [ADDR_W-1:0]     physical_address,
    input  wire logic [ADDR_W-1:0]     pc,
    input  wire logic                  hit,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WAY_W-1:0]           victim_way,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [1:0]            cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t                state_reg, state_next;
    logic [CLR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WAY_W-1:0]      victim_reg, victim_next;
    logic [1:0]            stream_th_reg, stream_th_next;
    logic [1:0]            reuse_th_reg, reuse_th_next;

    logic                  cmd_reg, cmd_next;
    logic [WAY_W-1:0]      way_reg, way_next;
    logic [LINE_W-1:0]     line_reg, line_next;
    logic                  hit_reg, hit_next;
    logic [PC_IDX_W-1:0]   pidx_reg, pidx_next;
    logic [ADDR_IDX_W-1:0] aidx_reg, aidx_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic                  round_reg, round_next;
    logic [2*WAYS-1:0]     work_reg, work_next;
    logic [LINE_W-1:0]     delta_reg, delta_next;
    logic [1:0]            score_reg, score_next;
    logic [1:0]            pc_ctr_reg, pc_ctr_next;
    logic [1:0]            addr_ctr_reg, addr_ctr_next;

    // Stores
    set_row_t              set_mem [SETS];
    logic [1:0]            pc_mem [PC_ENTRIES];
    logic [1:0]            addr_mem [ADDR_ENTRIES];

    set_row_t              set_rdata;
    logic [1:0]            pc_rdata;
    logic [1:0]            addr_rdata;

    logic                  set_we;
    logic [SET_W-1:0]      set_waddr;
    set_row_t              set_wdata;
    logic                  ctr_we;
    logic [PC_IDX_W-1:0]   pc_waddr;
    logic [ADDR_IDX_W-1:0] addr_waddr;
    logic [1:0]            pc_wdata;
    logic [1:0]            addr_wdata;

    logic                  accept;
    logic                  out_free;
    logic [ADDR_W-1:0]     pc_hash;
    logic [ADDR_W-1:0]     addr_hash;

    // Scan and aging unit
    logic                  scan_found;
    logic [WAY_W-1:0]      scan_way;
    logic [2*WAYS-1:0]     aged;

    // Update datapath
    logic [LINE_W-1:0]     delta;
    logic [1:0]            fill_value;
    logic [1:0]            old_value;
    logic [2*WAYS-1:0]     upd_rrip;

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign victim_way = victim_reg;
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;

    assign pc_hash   = (pc >> PC_SHIFT_LO) ^ (pc >> PC_SHIFT_HI);
    assign addr_hash = (physical_address >> LINE_LSB) ^ (physical_address >> ADDR_HASH_SHIFT);

    always_comb
    begin
        scan_found = 1'b0;
        scan_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (work_reg[2*w +: 2] == RRIP_DISTANT)
            begin
                scan_found = 1'b1;
                scan_way   = WAY_W'(w);
            end
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (work_reg[2*w +: 2] != RRIP_DISTANT)
                aged[2*w +: 2] = work_reg[2*w +: 2] + 2'd1;
            else
                aged[2*w +: 2] = RRIP_DISTANT;
        end
    end

    always_comb
    begin
        delta     = line_reg - set_rdata.last_line;
        old_value = set_rdata.rrip[2*way_reg +: 2];
        if (score_reg >= stream_th_reg)
            fill_value = RRIP_DISTANT;
        else if (pc_ctr_reg >= reuse_th_reg || addr_ctr_reg >= reuse_th_reg)
            fill_value = RRIP_NEAR;
        else
            fill_value = RRIP_DISTANT;
        upd_rrip = set_rdata.rrip;
        if (32'(way_reg) < WAYS)
        begin
            if (hit_reg)
            begin
                if (old_value != RRIP_NEAR)
                    upd_rrip[2*way_reg +: 2] = old_value - 2'd1;
            end
            else
            begin
                upd_rrip[2*way_reg +: 2] = fill_value;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        victim_next    = victim_reg;
        stream_th_next = stream_th_reg;
        reuse_th_next  = reuse_th_reg;
        cmd_next       = cmd_reg;
        way_next       = way_reg;
        line_next      = line_reg;
        hit_next       = hit_reg;
        pidx_next      = pidx_reg;
        aidx_next      = aidx_reg;
        set_next       = set_reg;
        round_next     = round_reg;
        work_next      = work_reg;
        delta_next     = delta_reg;
        score_next     = score_reg;
        pc_ctr_next    = pc_ctr_reg;
        addr_ctr_next  = addr_ctr_reg;

        set_we     = 1'b0;
        set_waddr  = set_reg;
        set_wdata  = set_rdata;
        ctr_we     = 1'b0;
        pc_waddr   = pidx_reg;
        addr_waddr = aidx_reg;
        pc_wdata   = pc_ctr_reg;
        addr_wdata = addr_ctr_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STREAM_THRESHOLD: stream_th_next = cfg_data;
                REG_REUSE_THRESHOLD:  reuse_th_next  = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                set_we           = (32'(clr_cnt_reg) < SETS);
                set_waddr        = clr_cnt_reg[SET_W-1:0];
                set_wdata.rrip   = {WAYS{RRIP_DISTANT}};
                set_wdata.last_line   = '0;
                set_wdata.prev_stride = '0;
                set_wdata.valid  = 1'b0;
                set_wdata.score  = '0;
                ctr_we           = 1'b1;
                pc_waddr         = clr_cnt_reg[PC_IDX_W-1:0];
                addr_waddr       = clr_cnt_reg[ADDR_IDX_W-1:0];
                pc_wdata         = CTR_MIN;
                addr_wdata       = CTR_MIN;
                clr_cnt_next     = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(CLEAR_N - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    way_next   = way;
                    line_next  = physical_address[LINE_LSB +: LINE_W];
                    hit_next   = hit;
                    pidx_next  = pc_hash[PC_IDX_W-1:0];
                    aidx_next  = addr_hash[ADDR_IDX_W-1:0];
                    set_next   = set_index;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (cmd_reg == CMD_VICTIM)
                begin
                    work_next  = set_rdata.rrip;
                    round_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    delta_next = set_rdata.prev_stride;
                    score_next = set_rdata.score;
                    if (set_rdata.valid)
                    begin
                        delta_next = delta;
                        if (delta != '0)
                        begin
                            if (delta == set_rdata.prev_stride)
                            begin
                                if (set_rdata.score != CTR_MAX)
                                    score_next = set_rdata.score + 2'd1;
                            end
                            else if (set_rdata.score != CTR_MIN)
                            begin
                                score_next = set_rdata.score - 2'd1;
                            end
                        end
                    end
                    pc_ctr_next   = pc_rdata;
                    addr_ctr_next = addr_rdata;
                    if (hit_reg)
                    begin
                        if (pc_rdata != CTR_MAX)
                            pc_ctr_next = pc_rdata + 2'd1;
                        if (addr_rdata != CTR_MAX)
                            addr_ctr_next = addr_rdata + 2'd1;
                    end
                    else
                    begin
                        if (pc_rdata != CTR_MIN)
                            pc_ctr_next = pc_rdata - 2'd1;
                        if (addr_rdata != CTR_MIN)
                            addr_ctr_next = addr_rdata - 2'd1;
                    end
                    ctr_we     = 1'b1;
                    pc_wdata   = pc_ctr_next;
                    addr_wdata = addr_ctr_next;
                    state_next = ST_WRITE;
                end
            end
            ST_SCAN:
            begin
                if (scan_found || round_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        victim_next    = scan_found ? scan_way : '0;
                        set_we         = 1'b1;
                        set_wdata.rrip = scan_found ? work_reg : aged;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    work_next  = aged;
                    round_next = 1'b1;
                end
            end
            ST_WRITE:
            begin
                set_we                = 1'b1;
                set_wdata.rrip        = upd_rrip;
                set_wdata.last_line   = line_reg;
                set_wdata.prev_stride = delta_reg;
                set_wdata.valid       = 1'b1;
                set_wdata.score       = score_reg;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            victim_reg    <= '0;
            stream_th_reg <= THRESH_RESET;
            reuse_th_reg  <= THRESH_RESET;
            cmd_reg       <= CMD_VICTIM;
            way_reg       <= '0;
            line_reg      <= '0;
            hit_reg       <= 1'b0;
            pidx_reg      <= '0;
            aidx_reg      <= '0;
            set_reg       <= '0;
            round_reg     <= 1'b0;
            work_reg      <= '0;
            delta_reg     <= '0;
            score_reg     <= '0;
            pc_ctr_reg    <= '0;
            addr_ctr_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            victim_reg    <= victim_next;
            stream_th_reg <= stream_th_next;
            reuse_th_reg  <= reuse_th_next;
            cmd_reg       <= cmd_next;
            way_reg       <= way_next;
            line_reg      <= line_next;
            hit_reg       <= hit_next;
            pidx_reg      <= pidx_next;
            aidx_reg      <= aidx_next;
            set_reg       <= set_next;
            round_reg     <= round_next;
            work_reg      <= work_next;
            delta_reg     <= delta_next;
            score_reg     <= score_next;
            pc_ctr_reg    <= pc_ctr_next;
            addr_ctr_reg  <= addr_ctr_next;
        end
    end

    // Reads are issued at the accepting edge, so the data is ready in the read state.
    always_ff @(posedge clk)
    begin
        if (set_we)
            set_mem[set_waddr] <= set_wdata;
        if (accept)
            set_rdata <= set_mem[set_index];
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
            pc_mem[pc_waddr] <= pc_wdata;
        if (accept)
            pc_rdata <= pc_mem[pc_hash[PC_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
            addr_mem[addr_waddr] <= addr_wdata;
        if (accept)
            addr_rdata <= addr_mem[addr_hash[ADDR_IDX_W-1:0]];
    end

    a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_SCAN)
        else $error("result raised outside the scan state");

    a_single_transaction: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while a transaction is in flight");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !set_we && !ctr_we)
        else $error("store written while idle");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready && !out_valid_reg)
        else $error("handshake active during the clearing pass");

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rrip_pkg::*;

    localparam int LINE_SPAN       = ADDR_W - LINE_LSB;
    localparam int HOT             = 6;
    localparam int PCS             = 4;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam bit [SET_W-1:0] STREAM_SET = 9;

    typedef struct packed {
        bit                 cmd;
        bit [SET_W-1:0]     set_index;
        bit [WAY_W-1:0]     way;
        bit [ADDR_W-1:0]    addr;
        bit [ADDR_W-1:0]    pc;
        bit                 hit;
    } access_t;

    typedef struct packed {
        bit                 is_reg;
        bit                 reg_idx;
        bit [1:0]           reg_val;
        access_t            acc;
        bit                 typed;
        bit [WAY_W-1:0]     want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   cmd;
    logic [SET_W-1:0]       set_index;
    logic [WAY_W-1:0]       way;
    logic [ADDR_W-1:0]      physical_address;
    logic [ADDR_W-1:0]      pc;
    logic                   hit;
    logic                   out_valid;
    logic                   out_ready;
    logic [WAY_W-1:0]       victim_way;
    logic                   cfg_we;
    logic                   cfg_index;
    logic [1:0]             cfg_data;

    // Shadow copy of the replacement state.
    bit [1:0]               rrv [SETS][WAYS];
    bit [LINE_W-1:0]        last_line [SETS];
    bit [LINE_W-1:0]        prev_stride [SETS];
    bit                     line_seen [SETS];
    bit [1:0]               score [SETS];
    bit [1:0]               pc_ctr [PC_ENTRIES];
    bit [1:0]               addr_ctr [ADDR_ENTRIES];
    bit [1:0]               stream_thr;
    bit [1:0]               reuse_thr;

    bit [WAY_W-1:0]         victims_due [$];
    row_t                   rows [$];
    int                     mismatches;
    int unsigned            gap_odds;
    int unsigned            stall_odds;
    bit                     hold_pending;

    rrip_ship_stream_replacement i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .set_index        (set_index),
        .way              (way),
        .physical_address (physical_address),
        .pc               (pc),
        .hit              (hit),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .victim_way       (victim_way),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic bit [ADDR_W-1:0] rand48();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic bit [1:0] saturate_step(input bit [1:0] v, input bit up);
        if (up)
            return (v == CTR_MAX) ? v : v + 2'd1;
        return (v == CTR_MIN) ? v : v - 2'd1;
    endfunction

    // Applies one transaction to the shadow state; returns 1 when it yields a victim.
    function automatic bit predict_access(input access_t a, output bit [WAY_W-1:0] victim);
        bit [SET_W-1:0]      s;
        bit                  found;
        int                  round;
        int                  w;
        bit [LINE_W-1:0]     line;
        bit [LINE_W-1:0]     delta;
        bit [ADDR_W-1:0]     pc_hash;
        bit [ADDR_W-1:0]     addr_hash;
        bit [PC_IDX_W-1:0]   pidx;
        bit [ADDR_IDX_W-1:0] aidx;
        s = a.set_index;
        victim = '0;
        if (a.cmd == CMD_VICTIM)
        begin
            found = 1'b0;
            for (round = 0; round < 2 && !found; round++)
            begin
                for (w = 0; w < WAYS && !found; w++)
                begin
                    if (rrv[s][w] == RRIP_DISTANT)
                    begin
                        found = 1'b1;
                        victim = WAY_W'(w);
                    end
                end
                // Nothing distant in this pass: age the whole set, then look again.
                if (!found)
                begin
                    for (w = 0; w < WAYS; w++)
                    begin
                        if (rrv[s][w] != RRIP_DISTANT)
                            rrv[s][w] = rrv[s][w] + 2'd1;
                    end
                end
            end
            return 1'b1;
        end

        line = a.addr[LINE_LSB +: LINE_W];
        delta = line - last_line[s];
        pc_hash = (a.pc >> PC_SHIFT_LO) ^ (a.pc >> PC_SHIFT_HI);
        addr_hash = (a.addr >> LINE_LSB) ^ (a.addr >> ADDR_HASH_SHIFT);
        pidx = pc_hash[PC_IDX_W-1:0];
        aidx = addr_hash[ADDR_IDX_W-1:0];

        // The very first line seen in a set only seeds the detector.
        if (line_seen[s])
        begin
            if (delta != '0)
            begin
                if (delta == prev_stride[s])
                    score[s] = saturate_step(score[s], 1'b1);
                else
                    score[s] = saturate_step(score[s], 1'b0);
            end
            prev_stride[s] = delta;
        end
        last_line[s] = line;
        line_seen[s] = 1'b1;

        pc_ctr[pidx] = saturate_step(pc_ctr[pidx], a.hit);
        addr_ctr[aidx] = saturate_step(addr_ctr[aidx], a.hit);

        if (a.hit)
        begin
            if (rrv[s][a.way] != RRIP_NEAR)
                rrv[s][a.way] = rrv[s][a.way] - 2'd1;
        end
        else if (score[s] >= stream_thr)
            rrv[s][a.way] = RRIP_DISTANT;
        else if (pc_ctr[pidx] >= reuse_thr || addr_ctr[aidx] >= reuse_thr)
            rrv[s][a.way] = RRIP_NEAR;
        else
            rrv[s][a.way] = RRIP_DISTANT;
        return 1'b0;
    endfunction

    function automatic row_t acc_row(input bit c, input bit [SET_W-1:0] s,
                                     input bit [WAY_W-1:0] w, input bit [ADDR_W-1:0] ad,
                                     input bit [ADDR_W-1:0] pcv, input bit h,
                                     input bit typed, input bit [WAY_W-1:0] want);
        row_t r;
        r = '0;
        r.acc.cmd = c;
        r.acc.set_index = s;
        r.acc.way = w;
        r.acc.addr = ad;
        r.acc.pc = pcv;
        r.acc.hit = h;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic row_t reg_row(input bit idx, input bit [1:0] val);
        row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Entered and left at a falling edge; valid is lowered only when a gap follows.
    task automatic send_access(input access_t a, input bit typed, input bit [WAY_W-1:0] want);
        bit [WAY_W-1:0] predicted;
        in_valid <= 1'b1;
        cmd <= a.cmd;
        set_index <= a.set_index;
        way <= a.way;
        physical_address <= a.addr;
        pc <= a.pc;
        hit <= a.hit;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (predict_access(a, predicted))
            victims_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    // Updates leave no result behind, so allow the pipeline to empty after the last victim.
    task automatic drain();
        in_valid <= 1'b0;
        while (victims_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input bit [1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STREAM_THRESHOLD)
            stream_thr = val;
        else
            reuse_thr = val;
        @(negedge clk);
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, stall_odds) == 0)
                stall_left = $urandom_range(1, 17);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        bit [WAY_W-1:0] due;
        if (rst_n && out_valid && out_ready)
        begin
            if (victims_due.size() == 0)
            begin
                $error("victim_way: expected none, actual %0d", victim_way);
                mismatches++;
            end
            else
            begin
                due = victims_due.pop_front();
                if (victim_way !== due)
                begin
                    $error("victim_way: expected %0d, actual %0d", due, victim_way);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        access_t                a;
        int                     i;
        int                     k;
        int                     p;
        int                     r;
        int                     slot;
        bit [31:0]              r32;
        bit [ADDR_W-1:0]        wide;
        bit [LINE_SPAN-1:0]     line;
        bit [1:0]               s_thr;
        bit [1:0]               r_thr;
        bit [SET_W-1:0]         hot_set [HOT];
        bit [LINE_SPAN-1:0]     next_line [HOT];
        bit [LINE_SPAN-1:0]     stride [HOT];
        bit [ADDR_W-1:0]        pc_pool [PCS];
        int                     stride_seq [16];

        stride_seq = '{0, 1, 1, 1, 2, 2, 5, 5, 0, 1, 1, 7, 7, 3, 3, 4};
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_VICTIM;
        set_index <= '0;
        way <= '0;
        physical_address <= '0;
        pc <= '0;
        hit <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_STREAM_THRESHOLD;
        cfg_data <= '0;
        mismatches = 0;
        hold_pending = 1'b0;
        gap_odds = 4;
        stall_odds = 5;
        stream_thr = THRESH_RESET;
        reuse_thr = THRESH_RESET;
        for (i = 0; i < SETS; i++)
        begin
            for (k = 0; k < WAYS; k++)
                rrv[i][k] = RRIP_DISTANT;
            last_line[i] = '0;
            prev_stride[i] = '0;
            line_seen[i] = 1'b0;
            score[i] = '0;
        end
        for (i = 0; i < PC_ENTRIES; i++)
            pc_ctr[i] = '0;
        for (i = 0; i < ADDR_ENTRIES; i++)
            addr_ctr[i] = '0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sets start fully distant, so the first victim in any set is way 0.
        rows.push_back(acc_row(CMD_VICTIM, '0, '0, '0, '0, 1'b0, 1'b1, '0));
        rows.push_back(acc_row(CMD_VICTIM, '1, '0, '0, '0, 1'b0, 1'b1, '0));
        rows.push_back(acc_row(CMD_UPDATE, '1, '1, '1, '1, 1'b1, 1'b0, '0));
        rows.push_back(acc_row(CMD_VICTIM, '1, '1, '1, '1, 1'b0, 1'b1, '0));
        rows.push_back(acc_row(CMD_UPDATE, '0, '0, '0, '0, 1'b0, 1'b0, '0));
        rows.push_back(reg_row(REG_STREAM_THRESHOLD, 2'd3));
        rows.push_back(reg_row(REG_REUSE_THRESHOLD, 2'd0));
        // Fill every way near while the stride pattern moves the stream score up and
        // down without ever reaching the streaming threshold.
        line = LINE_SPAN'(64);
        for (k = 0; k < WAYS; k++)
        begin
            line = line + LINE_SPAN'(stride_seq[k]);
            rows.push_back(acc_row(CMD_UPDATE, STREAM_SET, WAY_W'(k), {line, 6'd0},
                                   rand48(), 1'b0, 1'b0, '0));
        end
        // All near: two agings and a default answer, then one aging finds way 0.
        rows.push_back(acc_row(CMD_VICTIM, STREAM_SET, '0, '0, '0, 1'b0, 1'b1, '0));
        rows.push_back(acc_row(CMD_VICTIM, STREAM_SET, '0, '0, '0, 1'b0, 1'b1, '0));
        rows.push_back(acc_row(CMD_UPDATE, STREAM_SET, '0, {line, 6'd0}, '0, 1'b1, 1'b0, '0));
        rows.push_back(acc_row(CMD_VICTIM, STREAM_SET, '0, '0, '0, 1'b0, 1'b1, WAY_W'(1)));

        for (i = 0; i < rows.size(); i++)
        begin
            if (rows[i].is_reg)
            begin
                drain();
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            end
            else
            begin
                pause_sender();
                send_access(rows[i].acc, rows[i].typed, rows[i].want);
            end
        end

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin s_thr = 2'd2; r_thr = 2'd2; gap_odds = 5; stall_odds = 4; end
                1: begin s_thr = 2'd0; r_thr = 2'd3; gap_odds = 3; stall_odds = 6; end
                2: begin s_thr = 2'd3; r_thr = 2'd3; gap_odds = 0; stall_odds = 3; end
                3: begin s_thr = 2'd1; r_thr = 2'd1; gap_odds = 6; stall_odds = 0; end
                4: begin s_thr = 2'd0; r_thr = 2'd0; gap_odds = 4; stall_odds = 5; end
                default: begin s_thr = 2'd3; r_thr = 2'd0; gap_odds = 0; stall_odds = 0; end
            endcase
            drain();
            write_reg(REG_STREAM_THRESHOLD, s_thr);
            write_reg(REG_REUSE_THRESHOLD, r_thr);

            // A few hot sets with strided address streams and a small pool of PCs,
            // so that predictor counters saturate and sets fill up near.
            for (k = 0; k < HOT; k++)
            begin
                r32 = $urandom;
                hot_set[k] = r32[SET_W-1:0];
                wide = rand48();
                next_line[k] = wide[ADDR_W-1:LINE_LSB];
                stride[k] = LINE_SPAN'($urandom_range(1, 3));
                if (k % 3 == 2)
                    stride[k] = -stride[k];
            end
            for (k = 0; k < PCS; k++)
                pc_pool[k] = rand48();

            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p == 1 && k == 20)
                    hold_pending = 1'b1;
                r = $urandom_range(0, 99);
                r32 = $urandom;
                if (r < 10)
                begin
                    a.cmd = r32[0];
                    a.hit = r32[1];
                    a.way = r32[5:2];
                    a.set_index = r32[16:6];
                    a.addr = rand48();
                    a.pc = rand48();
                end
                else
                begin
                    slot = $urandom_range(0, HOT - 1);
                    a.cmd = (r < 40) ? CMD_VICTIM : CMD_UPDATE;
                    a.set_index = hot_set[slot];
                    a.way = r32[3:0];
                    a.hit = (r32[7:4] < 4'd10);
                    a.pc = pc_pool[r32[9:8]];
                    if (r32[12:10] == 3'd0)
                        a.addr = rand48();
                    else
                    begin
                        a.addr = {next_line[slot], r32[18:13]};
                        if (a.cmd == CMD_UPDATE)
                            next_line[slot] = next_line[slot] + stride[slot];
                        // Now and then the stride changes and the stream breaks.
                        if (r32[23:19] == 5'd0)
                            stride[slot] = LINE_SPAN'($urandom_range(1, 9));
                    end
                end
                pause_sender();
                send_access(a, 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0 && victims_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
